/* rtl/core/nsp_pkg.sv */
package nsp_pkg;

  // default limits for the sentence counters
  localparam int unsigned MaxFieldsDefault   = 64;
  localparam int unsigned MaxFieldLenDefault = 16;

  // kind of result item
  typedef enum logic [1:0] {
    EvChar     = 2'd0,
    EvFieldEnd = 2'd1,
    EvSentEnd  = 2'd2
  } event_e;

  // one result item plus its valid flag
  typedef struct packed {
    logic       valid;
    event_e     ev;
    logic [7:0] char_val;
    logic [5:0] field_num;
    logic [3:0] char_pos;
    logic       cksum_ok;
    logic       ovf;
  } result_t;

endpackage

/* rtl/core/nsp_core.sv */
module nsp_core import nsp_pkg::*; #(
  parameter int unsigned MAX_FIELDS    = MaxFieldsDefault,
  parameter int unsigned MAX_FIELD_LEN = MaxFieldLenDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  output result_t    res_o
);

  localparam int unsigned FcW  = $clog2(MAX_FIELDS);
  localparam int unsigned LenW = $clog2(MAX_FIELD_LEN);

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;

  localparam logic [FcW-1:0]  FcLast  = FcW'(MAX_FIELDS - 1);
  localparam logic [LenW-1:0] LenLast = LenW'(MAX_FIELD_LEN - 1);

  typedef enum logic [3:0] {
    PhHunt = 4'b0001,
    PhBody = 4'b0010,
    PhHex1 = 4'b0100,
    PhHex2 = 4'b1000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [7:0]      xor_q, xor_d;
  logic [3:0]      nib_q, nib_d;
  logic            hex_bad_q, hex_bad_d;
  logic [FcW-1:0]  fc_q, fc_d;
  logic [LenW-1:0] cc_q, cc_d;
  logic            ovf_q, ovf_d;

  logic            hex_ok;
  logic [3:0]      hex_nib;
  logic [FcW+5:0]  fc_ext;
  logic [LenW+3:0] cc_ext;
  logic [LenW+3:0] last_ext;

  // hex digit decode of the incoming byte
  always_comb begin
    hex_ok  = 1'b1;
    hex_nib = 4'd0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      hex_nib = 4'(byte_i - 8'h30);
    end else if (byte_i >= 8'h41 && byte_i <= 8'h46) begin
      hex_nib = 4'(byte_i - 8'h37);
    end else if (byte_i >= 8'h61 && byte_i <= 8'h66) begin
      hex_nib = 4'(byte_i - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // counters as seen on the output ports
  assign fc_ext   = (FcW + 6)'(fc_q);
  assign cc_ext   = (LenW + 4)'(cc_q);
  assign last_ext = (LenW + 4)'(LenLast);

  // next state and result for one byte
  always_comb begin
    phase_d   = phase_q;
    xor_d     = xor_q;
    nib_d     = nib_q;
    hex_bad_d = hex_bad_q;
    fc_d      = fc_q;
    cc_d      = cc_q;
    ovf_d     = ovf_q;

    res_o           = '0;
    res_o.ev        = EvChar;
    res_o.field_num = fc_ext[5:0];
    res_o.ovf       = ovf_q;

    unique case (phase_q)
      PhHunt: begin
        if (byte_i == ChDollar) begin
          phase_d   = PhBody;
          xor_d     = 8'd0;
          nib_d     = 4'd0;
          hex_bad_d = 1'b0;
          fc_d      = '0;
          cc_d      = '0;
          ovf_d     = 1'b0;
        end
      end
      PhBody: begin
        res_o.valid = 1'b1;
        if (byte_i == ChStar) begin
          res_o.ev       = EvFieldEnd;
          res_o.char_pos = cc_ext[3:0];
          phase_d        = PhHex1;
        end else begin
          xor_d = xor_q ^ byte_i;
          if (byte_i == ChComma) begin
            res_o.ev       = EvFieldEnd;
            res_o.char_pos = cc_ext[3:0];
            cc_d           = '0;
            if (fc_q < FcLast) begin
              fc_d = FcW'(fc_q + 1'b1);
            end else begin
              ovf_d = 1'b1;
            end
          end else if (cc_q >= LenLast) begin
            // long field: stick at the last position and flag it
            cc_d           = LenLast;
            ovf_d          = 1'b1;
            res_o.char_val = byte_i;
            res_o.char_pos = last_ext[3:0];
            res_o.ovf      = 1'b1;
          end else begin
            res_o.char_val = byte_i;
            res_o.char_pos = cc_ext[3:0];
            cc_d           = LenW'(cc_q + 1'b1);
          end
        end
      end
      PhHex1: begin
        hex_bad_d = hex_bad_q | ~hex_ok;
        nib_d     = hex_ok ? hex_nib : 4'd0;
        phase_d   = PhHex2;
      end
      PhHex2: begin
        res_o.valid    = 1'b1;
        res_o.ev       = EvSentEnd;
        res_o.cksum_ok = hex_ok && !hex_bad_q && ({nib_q, hex_nib} == xor_q);
        phase_d        = PhHunt;
      end
      default: begin
        phase_d = PhHunt;
      end
    endcase
  end

  // sentence state, updated on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      xor_q     <= 8'd0;
      nib_q     <= 4'd0;
      hex_bad_q <= 1'b0;
      fc_q      <= '0;
      cc_q      <= '0;
      ovf_q     <= 1'b0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      xor_q     <= xor_d;
      nib_q     <= nib_d;
      hex_bad_q <= hex_bad_d;
      fc_q      <= fc_d;
      cc_q      <= cc_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

/* rtl/core/nmea_sentence_parser.sv */
// channel | signals                                   | direction
// in      | in_valid_i, in_ready_o, in_byte_i         | byte in
// out     | out_valid_o, out_ready_i, event_res_o,    | result item out
//         | char_out_o, field_number_o, char_position_o,
//         | checksum_ok_o, overflow_o                 |
// one byte is taken every cycle unless a stalled result holds it off; its result, if any,
// shows in the output register on the next cycle, set by the single-pass decode in nsp_core
// reset puts the parser in start hunting with the output register empty
// a new byte is taken while the output register is empty or being drained;
// a stalled result blocks only further input
module nmea_sentence_parser import nsp_pkg::*; #(
  parameter int unsigned MAX_FIELDS    = MaxFieldsDefault,
  parameter int unsigned MAX_FIELD_LEN = MaxFieldLenDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] event_res_o,
  output logic [7:0] char_out_o,
  output logic [5:0] field_number_o,
  output logic [3:0] char_position_o,
  output logic       checksum_ok_o,
  output logic       overflow_o
);

  logic    fire;
  result_t res;
  result_t res_q;
  logic    out_valid_q, out_valid_d;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign fire       = in_valid_i & in_ready_o;

  nsp_core #(
    .MAX_FIELDS   (MAX_FIELDS),
    .MAX_FIELD_LEN(MAX_FIELD_LEN)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .byte_i(in_byte_i),
    .res_o (res)
  );

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = res.valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (fire && res.valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = res_q.ev;
  assign char_out_o      = res_q.char_val;
  assign field_number_o  = res_q.field_num;
  assign char_position_o = res_q.char_pos;
  assign checksum_ok_o   = res_q.cksum_ok;
  assign overflow_o      = res_q.ovf;

endmodule
